>>> hdl/servo_lid_gesture_controller_defines.svh
// Assertion macros for the servo lid controller.
// SLGC_ASSERT_NOW: consequent checked in the same cycle as the antecedent.
// SLGC_ASSERT_NEXT: consequent checked in the cycle after the antecedent.
`ifndef SERVO_LID_GESTURE_CONTROLLER_DEFINES_SVH
`define SERVO_LID_GESTURE_CONTROLLER_DEFINES_SVH
`ifndef SYNTHESIS
`define SLGC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define SLGC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define SLGC_ASSERT_NOW(label, ante, cons, msg)
`define SLGC_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

>>> hdl/slgc_pkg.sv
`timescale 1ns / 1ps
package slgc_pkg;

	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 16;
	localparam int IN_ITEM_W = 42;
	localparam int OUT_ITEM_W = 12;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CLOSE_ANGLE   = 3'd0,
		CFG_OPEN_ANGLE    = 3'd1,
		CFG_RAMP_STEP     = 3'd2,
		CFG_PRESS_WINDOW  = 3'd3,
		CFG_HOLD_CLOSE    = 3'd4
	} cfg_index_t;

	localparam logic [7:0]  CLOSE_ANGLE_RST  = 8'd53;
	localparam logic [7:0]  OPEN_ANGLE_RST   = 8'd75;
	localparam logic [7:0]  RAMP_STEP_RST    = 8'd100;
	localparam logic [15:0] PRESS_WINDOW_RST = 16'd500;
	localparam logic [15:0] HOLD_CLOSE_RST   = 16'd800;

	// remote switch gesture steps
	localparam logic [1:0] RS_IDLE  = 2'd0;
	localparam logic [1:0] RS_ARMED = 2'd1;
	localparam logic [1:0] RS_FIRED = 2'd2;

	localparam logic [1:0] PRESS_OPEN = 2'd2;
	localparam logic [1:0] PRESS_MAX  = 2'd3;

	// declared MSB first, so the last field (starting) lands in bit 0
	typedef struct packed {
		logic [31:0] now_ticks;
		logic        clear_sentry;
		logic        buff_hit_active;
		logic        key_x_and_g;
		logic        key_close_any;
		logic        key_s;
		logic        key_r;
		logic        sw1_up;
		logic        sw2_middle;
		logic        key_mode;
		logic        starting;
	} in_item_t;

	typedef struct packed {
		logic       sentry_flag;
		logic       open_pulse;
		logic       lid_opening;
		logic       lid_open;
		logic [7:0] pwm_value;
	} out_item_t;

	typedef struct packed {
		logic [7:0]  close_angle;
		logic [7:0]  open_angle;
		logic [7:0]  ramp_step;
		logic [15:0] double_press_window;
		logic [15:0] hold_close_time;
	} cfg_t;

endpackage

>>> hdl/servo_lid_gesture_controller.sv
`timescale 1ns / 1ps
// Servo lid controller, one control tick per item. An item is taken in every
// clock cycle while results are being taken: the input register feeds the step
// logic (remote gesture, keyboard double press and hold, ramp and clamp, sentry
// flag) whose result goes into the output register, from which it is offered.
// While a result waits unaccepted, one more item is taken into the input
// register and after that the input is held off until the result goes.
// Registers are written through cfg_we/cfg_index/cfg_data; the user must do so
// only while no item is in flight, and the block itself does not enforce this.
module servo_lid_gesture_controller import slgc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// starting, key_mode, sw2_middle, sw1_up, key_r, key_s, key_close_any,
	// key_x_and_g, buff_hit_active, clear_sentry, now_ticks[31:0], zero pad
	input  logic [S_TDATA_W-1:0]  s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// pwm_value[7:0], lid_open, lid_opening, open_pulse, sentry_flag, zero pad
	output logic [M_TDATA_W-1:0]  m_tdata
);

	cfg_t      cfg_q;
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t res_s2;
	logic      valid_s2;
	out_item_t res;
	logic      advance;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;
	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(M_TDATA_W-OUT_ITEM_W){1'b0}}, res_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.close_angle         <= CLOSE_ANGLE_RST;
			cfg_q.open_angle          <= OPEN_ANGLE_RST;
			cfg_q.ramp_step           <= RAMP_STEP_RST;
			cfg_q.double_press_window <= PRESS_WINDOW_RST;
			cfg_q.hold_close_time     <= HOLD_CLOSE_RST;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_CLOSE_ANGLE:  cfg_q.close_angle         <= cfg_data[7:0];
				CFG_OPEN_ANGLE:   cfg_q.open_angle          <= cfg_data[7:0];
				CFG_RAMP_STEP:    cfg_q.ramp_step           <= cfg_data[7:0];
				CFG_PRESS_WINDOW: cfg_q.double_press_window <= cfg_data;
				CFG_HOLD_CLOSE:   cfg_q.hold_close_time     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				valid_s2 <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1 <= in_item_t'(s_tdata[IN_ITEM_W-1:0]);
		end
		if (advance) begin
			res_s2 <= res;
		end
	end

	slgc_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.item    (item_s1),
		.cfg     (cfg_q),
		.res     (res)
	);

endmodule

>>> hdl/slgc_core.sv
`timescale 1ns / 1ps
`include "servo_lid_gesture_controller_defines.svh"
module slgc_core import slgc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      advance,
	input  in_item_t  item,
	input  cfg_t      cfg,
	output out_item_t res
);

	logic [1:0]  remote_step_q, remote_step_n;
	logic        key_open_q, key_open_n;
	logic        r_released_q, r_released_n;
	logic [1:0]  press_count_q, press_count_n;
	logic [31:0] last_r_time_q, last_r_time_n;
	logic [31:0] s_hold_start_q, s_hold_start_n;
	logic [7:0]  target_q, target_n;
	logic [7:0]  actual_q, actual_n;
	logic        from_remote_q, from_remote_n;
	logic        sentry_q, sentry_n;

	logic        pulse;
	logic [31:0] r_gap, s_gap;
	logic [8:0]  up_sum;
	logic [7:0]  down_val;

	always_comb begin
		remote_step_n  = remote_step_q;
		key_open_n     = key_open_q;
		r_released_n   = r_released_q;
		press_count_n  = press_count_q;
		last_r_time_n  = last_r_time_q;
		s_hold_start_n = s_hold_start_q;
		target_n       = target_q;
		actual_n       = actual_q;
		from_remote_n  = from_remote_q;
		pulse          = 1'b0;
		r_gap          = item.now_ticks - last_r_time_q;
		s_gap          = '0;
		up_sum         = '0;
		down_val       = '0;

		sentry_n = item.key_x_and_g | (sentry_q & ~item.clear_sentry);

		if (item.starting) begin
			target_n      = cfg.close_angle;
			actual_n      = cfg.close_angle;
			r_released_n  = 1'b1;
			press_count_n = '0;
		end else begin
			// release-then-raise of switch 1 with switch 2 held in the middle
			if (item.sw2_middle) begin
				if (item.sw1_up) begin
					if (remote_step_q == RS_ARMED) begin
						remote_step_n = RS_FIRED;
					end else if (remote_step_q == RS_FIRED) begin
						remote_step_n = RS_IDLE;
					end
				end else begin
					remote_step_n = RS_ARMED;
				end
			end else begin
				remote_step_n = RS_IDLE;
			end
			if (remote_step_n == RS_FIRED) begin
				target_n = (target_q == cfg.open_angle) ? cfg.close_angle : cfg.open_angle;
			end

			if (item.key_mode) begin
				if (from_remote_q) begin
					key_open_n    = 1'b0;
					target_n      = cfg.close_angle;
					from_remote_n = 1'b0;
				end
				if (!key_open_n) begin
					if (!item.key_r) begin
						r_released_n = 1'b1;
						if (r_gap > {16'b0, cfg.double_press_window}) begin
							press_count_n = '0;
						end
					end
					if (item.key_r && r_released_n && !item.buff_hit_active) begin
						last_r_time_n = item.now_ticks;
						r_released_n  = 1'b0;
						if (press_count_n != PRESS_MAX) begin
							press_count_n = press_count_n + 2'd1;
						end
					end
					if (press_count_n >= PRESS_OPEN) begin
						key_open_n     = 1'b1;
						target_n       = cfg.open_angle;
						s_hold_start_n = item.now_ticks;
						pulse          = 1'b1;
					end else begin
						target_n = cfg.close_angle;
					end
				end else begin
					if (!item.key_r) begin
						r_released_n = 1'b1;
					end
					if (!item.key_s) begin
						s_hold_start_n = item.now_ticks;
					end
					s_gap = item.now_ticks - s_hold_start_n;
					// on close the target only drops on the next keyboard tick
					if (s_gap > {16'b0, cfg.hold_close_time} || item.key_close_any) begin
						key_open_n = 1'b0;
					end else begin
						target_n = cfg.open_angle;
					end
					press_count_n = '0;
				end
			end else begin
				key_open_n    = 1'b0;
				r_released_n  = 1'b1;
				press_count_n = '0;
				from_remote_n = 1'b1;
			end
		end

		// ramp toward the target, clamped there
		if (actual_n < target_n) begin
			up_sum   = {1'b0, actual_n} + {1'b0, cfg.ramp_step};
			actual_n = (up_sum > {1'b0, target_n}) ? target_n : up_sum[7:0];
		end else if (actual_n > target_n) begin
			down_val = (actual_n > cfg.ramp_step) ? (actual_n - cfg.ramp_step) : 8'd0;
			actual_n = (down_val < target_n) ? target_n : down_val;
		end

		res.pwm_value   = actual_n;
		res.lid_open    = (actual_n == cfg.open_angle);
		res.lid_opening = (target_n == cfg.open_angle);
		res.open_pulse  = pulse;
		res.sentry_flag = sentry_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			remote_step_q  <= RS_IDLE;
			key_open_q     <= 1'b0;
			r_released_q   <= 1'b1;
			press_count_q  <= '0;
			last_r_time_q  <= '0;
			s_hold_start_q <= '0;
			target_q       <= '0;
			actual_q       <= '0;
			from_remote_q  <= 1'b1;
			sentry_q       <= 1'b0;
		end else if (advance) begin
			remote_step_q  <= remote_step_n;
			key_open_q     <= key_open_n;
			r_released_q   <= r_released_n;
			press_count_q  <= press_count_n;
			last_r_time_q  <= last_r_time_n;
			s_hold_start_q <= s_hold_start_n;
			target_q       <= target_n;
			actual_q       <= actual_n;
			from_remote_q  <= from_remote_n;
			sentry_q       <= sentry_n;
		end
	end

	`SLGC_ASSERT_NEXT(a_start_closes, advance && item.starting,
		actual_q == $past(cfg.close_angle) && target_q == $past(cfg.close_angle),
		"starting item did not park the lid at the close angle")
	`SLGC_ASSERT_NEXT(a_sentry_sets, advance && item.key_x_and_g, sentry_q,
		"sentry flag not latched by X and G")
	`SLGC_ASSERT_NOW(a_pulse_opens, advance && res.open_pulse, res.lid_opening,
		"open pulse without an open target")
	`SLGC_ASSERT_NOW(a_key_open_rise, $rose(key_open_q),
		$past(advance && item.key_mode && !item.starting),
		"keyboard open state entered outside a keyboard item")

endmodule

>>> tb/sv/servo_lid_tick_checker.sv
`timescale 1ns / 1ps
module servo_lid_tick_checker import slgc_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [M_TDATA_W-1:0]  m_tdata,
	output int                    fail_count,
	output int                    pending,
	output int                    compared,
	output int                    pulses
);

	cfg_t       regs;
	logic [1:0] gest_step;
	logic       kb_open;
	logic       r_free;
	logic [1:0] r_count;
	logic [31:0] r_stamp;
	logic [31:0] s_stamp;
	logic [7:0] tgt;
	logic [7:0] act;
	logic       from_remote;
	logic       sentry;

	out_item_t  lid_expected [$];

	initial begin
		fail_count = 0;
		pending = 0;
		compared = 0;
		pulses = 0;
	end

	// one control tick of the lid controller; updates the shadow state
	function automatic out_item_t advance_lid(in_item_t t);
		logic       pulse;
		logic [31:0] gap;
		logic [8:0] up;
		logic [7:0] down;
		out_item_t  o;
		pulse = 1'b0;
		if (t.clear_sentry)
			sentry = 1'b0;
		if (t.starting) begin
			tgt = regs.close_angle;
			act = regs.close_angle;
			r_free = 1'b1;
			r_count = '0;
		end else begin
			if (t.sw2_middle) begin
				if (t.sw1_up) begin
					if (gest_step == RS_ARMED)
						gest_step = RS_FIRED;
					else if (gest_step == RS_FIRED)
						gest_step = RS_IDLE;
				end else begin
					gest_step = RS_ARMED;
				end
			end else begin
				gest_step = RS_IDLE;
			end
			if (gest_step == RS_FIRED)
				tgt = (tgt == regs.open_angle) ? regs.close_angle : regs.open_angle;

			if (t.key_mode) begin
				if (from_remote) begin
					kb_open = 1'b0;
					tgt = regs.close_angle;
					from_remote = 1'b0;
				end
				if (!kb_open) begin
					if (!t.key_r) begin
						r_free = 1'b1;
						gap = t.now_ticks - r_stamp;
						if (gap > {16'd0, regs.double_press_window})
							r_count = '0;
					end
					if (t.key_r && r_free && !t.buff_hit_active) begin
						r_stamp = t.now_ticks;
						r_free = 1'b0;
						if (r_count < PRESS_MAX)
							r_count = r_count + 2'd1;
					end
					if (r_count >= PRESS_OPEN) begin
						kb_open = 1'b1;
						tgt = regs.open_angle;
						s_stamp = t.now_ticks;
						pulse = 1'b1;
					end else begin
						tgt = regs.close_angle;
					end
				end else begin
					if (!t.key_r)
						r_free = 1'b1;
					if (!t.key_s)
						s_stamp = t.now_ticks;
					gap = t.now_ticks - s_stamp;
					// close request leaves the target open for this tick
					if (gap > {16'd0, regs.hold_close_time} || t.key_close_any)
						kb_open = 1'b0;
					else
						tgt = regs.open_angle;
					r_count = '0;
				end
			end else begin
				kb_open = 1'b0;
				r_free = 1'b1;
				r_count = '0;
				from_remote = 1'b1;
			end
		end

		if (act < tgt) begin
			up = {1'b0, act} + {1'b0, regs.ramp_step};
			act = (up > {1'b0, tgt}) ? tgt : up[7:0];
		end else if (act > tgt) begin
			down = (act > regs.ramp_step) ? act - regs.ramp_step : 8'd0;
			act = (down < tgt) ? tgt : down;
		end

		if (t.key_x_and_g)
			sentry = 1'b1;

		o.pwm_value = act;
		o.lid_open = (act == regs.open_angle);
		o.lid_opening = (tgt == regs.open_angle);
		o.open_pulse = pulse;
		o.sentry_flag = sentry;
		return o;
	endfunction

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			fail_count++;
			if (fail_count <= 10)
				$display("%0t: result %0d, %s expected %0d got %0d",
					$realtime, compared, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t got;
		out_item_t want;
		if (!arst_n) begin
			regs.close_angle = CLOSE_ANGLE_RST;
			regs.open_angle = OPEN_ANGLE_RST;
			regs.ramp_step = RAMP_STEP_RST;
			regs.double_press_window = PRESS_WINDOW_RST;
			regs.hold_close_time = HOLD_CLOSE_RST;
			gest_step = RS_IDLE;
			kb_open = 1'b0;
			r_free = 1'b1;
			r_count = '0;
			r_stamp = '0;
			s_stamp = '0;
			tgt = '0;
			act = '0;
			from_remote = 1'b1;
			sentry = 1'b0;
			lid_expected.delete();
			pending = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = out_item_t'(m_tdata[OUT_ITEM_W-1:0]);
				if (lid_expected.size() == 0) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: unexpected result pwm %0d flags %b", $realtime,
							got.pwm_value,
							{got.lid_open, got.lid_opening, got.open_pulse, got.sentry_flag});
				end else begin
					want = lid_expected.pop_front();
					check_field("pwm_value", want.pwm_value, got.pwm_value);
					check_field("lid_open", want.lid_open, got.lid_open);
					check_field("lid_opening", want.lid_opening, got.lid_opening);
					check_field("open_pulse", want.open_pulse, got.open_pulse);
					check_field("sentry_flag", want.sentry_flag, got.sentry_flag);
					compared++;
				end
			end

			// writes are masked to register width; spare indexes do nothing
			if (cfg_we) begin
				case (cfg_index)
					CFG_CLOSE_ANGLE:  regs.close_angle = cfg_data[7:0];
					CFG_OPEN_ANGLE:   regs.open_angle = cfg_data[7:0];
					CFG_RAMP_STEP:    regs.ramp_step = cfg_data[7:0];
					CFG_PRESS_WINDOW: regs.double_press_window = cfg_data;
					CFG_HOLD_CLOSE:   regs.hold_close_time = cfg_data;
					default: ;
				endcase
			end

			if (s_tvalid && s_tready) begin
				want = advance_lid(in_item_t'(s_tdata[IN_ITEM_W-1:0]));
				if (want.open_pulse)
					pulses++;
				lid_expected.push_back(want);
			end
			pending = lid_expected.size();
		end
	end

endmodule

>>> tb/sv/servo_lid_gesture_controller_tb.sv
`timescale 1ns / 1ps
module servo_lid_gesture_controller_tb;
	import slgc_pkg::*;

	localparam int WATCHDOG_LIMIT = 3000;
	localparam int LONG_STALL = 80;
	localparam int NUM_REGS = int'(CFG_HOLD_CLOSE) + 1;
	localparam logic [CFG_IDX_W-1:0] SPARE_IDX_FIRST = CFG_IDX_W'(int'(CFG_HOLD_CLOSE) + 1);

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;

	int fail_count;
	int pending;
	int compared;
	int pulses;

	cfg_t        shadow;
	int unsigned now_t;
	int          burst_left = 0;
	int          ticks_sent = 0;
	int          settings_used = 1;
	int          long_stall_req = 0;
	int          stall_done = 0;
	int          stall_left = 0;
	int unsigned rx_cyc = 0;
	int          idle_cycles = 0;

	servo_lid_gesture_controller dut (.*);

	servo_lid_tick_checker watch (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// receiver: rotating stall patterns, plus long hold-offs on request
	always @(posedge clk) begin
		rx_cyc <= rx_cyc + 1;
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if (stall_done != long_stall_req) begin
			stall_done <= stall_done + 1;
			stall_left <= LONG_STALL;
			m_tready <= 1'b0;
		end else begin
			case (rx_cyc[9:8])
				2'd0: m_tready <= 1'b1;
				2'd1: m_tready <= 1'($urandom_range(0, 1));
				2'd2: m_tready <= (rx_cyc % 5) != 0;
				default: m_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("servo_lid_gesture_controller regression: fail");
			$finish;
		end
	end

	function automatic in_item_t mk(int st, int kb, int sw2, int sw1, int r, int s, int cl,
			int xg, int bf, int clr, logic [31:0] t);
		in_item_t it;
		it.starting = st[0];
		it.key_mode = kb[0];
		it.sw2_middle = sw2[0];
		it.sw1_up = sw1[0];
		it.key_r = r[0];
		it.key_s = s[0];
		it.key_close_any = cl[0];
		it.key_x_and_g = xg[0];
		it.buff_hit_active = bf[0];
		it.clear_sentry = clr[0];
		it.now_ticks = t;
		return it;
	endfunction

	function automatic in_item_t quiet(bit kb);
		in_item_t it;
		it = '0;
		it.key_mode = kb;
		return it;
	endfunction

	// mostly within the span, sometimes beyond it, now and then a wild jump
	function automatic int unsigned tick_gap(int unsigned span);
		case ($urandom_range(0, 9))
			0: return $urandom();
			1, 2: return $urandom_range(0, 3 * span + 3);
			default: return $urandom_range(0, span + 1);
		endcase
	endfunction

	task automatic offer(input in_item_t it);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
				: $urandom_range(1, 8);
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= {{(S_TDATA_W - IN_ITEM_W){1'b0}}, it};
		do @(posedge clk); while (!s_tready);
		ticks_sent++;
	endtask

	task automatic send_tick(input in_item_t it, input int unsigned span);
		now_t += tick_gap(span);
		it.now_ticks = now_t;
		it.key_x_and_g |= ($urandom_range(0, 15) == 0);
		it.clear_sentry |= ($urandom_range(0, 15) == 0);
		offer(it);
	endtask

	// stop sending and let every outstanding result come out
	task automatic drain();
		s_tvalid <= 1'b0;
		burst_left = 0;
		do @(negedge clk); while (pending != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_regs(input cfg_t c);
		logic [CFG_DATA_W-1:0] vals [NUM_REGS];
		cfg_index_t k;
		vals = '{{8'($urandom()), c.close_angle}, {8'($urandom()), c.open_angle},
			{8'($urandom()), c.ramp_step}, c.double_press_window, c.hold_close_time};
		k = k.first();
		cfg_we <= 1'b1;
		do begin
			cfg_index <= k;
			cfg_data <= vals[k];
			@(posedge clk);
			k = k.next();
		end while (k != k.first());
		// a spare index must leave every register alone
		cfg_index <= SPARE_IDX_FIRST + CFG_IDX_W'($urandom_range(0, 2));
		cfg_data <= CFG_DATA_W'($urandom());
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		shadow = c;
		settings_used++;
	endtask

	task automatic random_scenario();
		in_item_t    it;
		int unsigned w;
		int unsigned h;
		w = shadow.double_press_window;
		h = shadow.hold_close_time;
		case ($urandom_range(0, 9))
			0, 1: begin
				// remote gesture: switch 1 down then up with switch 2 in the middle
				it = quiet($urandom_range(0, 3) == 0);
				it.sw2_middle = 1'b1;
				repeat ($urandom_range(1, 3)) send_tick(it, w);
				it.sw1_up = 1'b1;
				if ($urandom_range(0, 5) == 0)
					it.sw2_middle = 1'b0;
				repeat ($urandom_range(1, 3)) send_tick(it, w);
			end
			2, 3, 4, 5, 6: begin
				it = quiet(1'b1);
				it.key_r = 1'b1;
				it.buff_hit_active = ($urandom_range(0, 7) == 0);
				send_tick(it, w);
				it.key_r = 1'b0;
				it.buff_hit_active = 1'b0;
				repeat ($urandom_range(1, 2)) send_tick(it, w / 2);
				it.key_r = 1'b1;
				it.buff_hit_active = ($urandom_range(0, 7) == 0);
				send_tick(it, w / 2);
				case ($urandom_range(0, 2))
					0: begin
						it = quiet(1'b1);
						it.key_s = 1'b1;
						repeat ($urandom_range(2, 6)) begin
							it.key_r = 1'($urandom_range(0, 1));
							send_tick(it, h / 2);
						end
						it.key_s = 1'b0;
						send_tick(it, h);
					end
					1: begin
						it = quiet(1'b1);
						it.key_close_any = 1'b1;
						send_tick(it, w);
						send_tick(quiet(1'b1), w);
					end
					default: begin
						it = quiet(1'b1);
						repeat ($urandom_range(1, 3)) begin
							it.key_r = 1'($urandom_range(0, 1));
							send_tick(it, w);
						end
					end
				endcase
			end
			7: begin
				it = quiet(1'($urandom_range(0, 1)));
				it.key_close_any = 1'b1;
				send_tick(it, w);
			end
			8: begin
				it = quiet(1'($urandom_range(0, 1)));
				it.starting = 1'b1;
				send_tick(it, w);
			end
			default: begin
				repeat ($urandom_range(1, 4)) begin
					it = {$urandom(), 10'($urandom())};
					now_t = it.now_ticks;
					offer(it);
				end
			end
		endcase
	endtask

	task automatic random_phase(input int n_ticks, input bit squeeze, input bit pause_mid);
		int goal;
		int half;
		goal = ticks_sent + n_ticks;
		half = ticks_sent + n_ticks / 2;
		if (squeeze) begin
			// long receiver hold-off while the sender keeps offering
			long_stall_req <= long_stall_req + 1;
			burst_left = LONG_STALL + 40;
		end
		while (ticks_sent < goal) begin
			random_scenario();
			if (pause_mid && ticks_sent >= half) begin
				drain();
				pause_mid = 1'b0;
			end
		end
		drain();
	endtask

	initial begin
		cfg_t c;
		shadow.close_angle = CLOSE_ANGLE_RST;
		shadow.open_angle = OPEN_ANGLE_RST;
		shadow.ramp_step = RAMP_STEP_RST;
		shadow.double_press_window = PRESS_WINDOW_RST;
		shadow.hold_close_time = HOLD_CLOSE_RST;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, reset register values
		offer(mk(1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32'd0));
		offer(mk(0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 32'd10));
		offer(mk(0, 0, 1, 1, 0, 0, 0, 0, 0, 0, 32'd20));
		offer(mk(0, 0, 1, 1, 0, 0, 0, 0, 0, 0, 32'd30));
		offer(mk(0, 0, 1, 0, 0, 0, 0, 0, 0, 0, 32'd40));
		// toggle on the first keyboard tick, which overrides it
		offer(mk(0, 1, 1, 1, 0, 0, 0, 0, 0, 0, 32'd50));
		offer(mk(0, 1, 0, 0, 1, 0, 0, 0, 0, 0, 32'd100));
		offer(mk(0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 32'd200));
		offer(mk(0, 1, 0, 0, 1, 0, 0, 0, 0, 0, 32'd300));
		offer(mk(0, 1, 0, 0, 0, 1, 0, 0, 0, 0, 32'd310));
		offer(mk(0, 1, 0, 0, 0, 1, 0, 0, 0, 0, 32'd1200));
		offer(mk(0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 32'd1210));
		offer(mk(0, 1, 0, 0, 1, 0, 0, 0, 1, 0, 32'd1300));
		offer(mk(0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 32'd1400));
		// double press across the tick counter wrap
		offer(mk(0, 1, 0, 0, 1, 0, 0, 0, 0, 0, 32'hFFFF_FFF0));
		offer(mk(0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFF8));
		offer(mk(0, 1, 0, 0, 1, 0, 0, 0, 0, 0, 32'h0000_0005));
		offer(mk(0, 1, 0, 0, 0, 0, 1, 0, 0, 0, 32'h0000_0010));
		// press count dropped once the window runs out
		offer(mk(0, 1, 0, 0, 1, 0, 0, 0, 0, 0, 32'h0000_0020));
		offer(mk(0, 1, 0, 0, 0, 0, 0, 0, 0, 0, 32'h0000_0400));
		offer(mk(0, 1, 0, 0, 1, 0, 0, 0, 0, 0, 32'h0000_0410));
		offer(mk(0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 32'h0000_0500));
		offer(mk(0, 0, 0, 0, 0, 0, 0, 1, 0, 1, 32'h0000_0510));
		offer(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 32'h0000_0520));
		offer(mk(1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 32'hFFFF_FFFF));
		offer(mk(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32'h0000_0000));
		now_t = 32'h1000;
		random_phase(40, 1'b0, 1'b0);

		c = '{close_angle: 8'd0, open_angle: 8'd255, ramp_step: 8'd255,
			double_press_window: 16'd1, hold_close_time: 16'd1};
		program_regs(c);
		random_phase(58, 1'b1, 1'b0);

		c = '{close_angle: 8'd255, open_angle: 8'd0, ramp_step: 8'd1,
			double_press_window: 16'hFFFF, hold_close_time: 16'hFFFF};
		program_regs(c);
		random_phase(58, 1'b0, 1'b0);

		// equal angles and a zero ramp step: the angle must stay put
		c.close_angle = 8'($urandom());
		c.open_angle = c.close_angle;
		c.ramp_step = 8'd0;
		c.double_press_window = 16'($urandom_range(1, 1000));
		c.hold_close_time = 16'($urandom_range(1, 1000));
		program_regs(c);
		random_phase(58, 1'b0, 1'b0);

		repeat (3) begin
			c.close_angle = 8'($urandom());
			c.open_angle = 8'($urandom());
			c.ramp_step = 8'($urandom_range(1, 255));
			c.double_press_window = ($urandom_range(0, 3) == 0)
				? 16'($urandom_range(1, 65535)) : 16'($urandom_range(1, 1000));
			c.hold_close_time = ($urandom_range(0, 3) == 0)
				? 16'($urandom_range(1, 65535)) : 16'($urandom_range(1, 1000));
			program_regs(c);
			random_phase(58, settings_used == 5, settings_used == 6);
		end

		drain();
		repeat (8) @(posedge clk);

		$display("Covered %0d ticks over %0d register settings: remote gestures, double presses,",
			ticks_sent, settings_used);
		$display("S hold and key closes, counter wrap, zero step; %0d results, %0d open pulses.",
			compared, pulses);
		if (fail_count == 0)
			$display("servo_lid_gesture_controller regression: pass");
		else
			$display("servo_lid_gesture_controller regression: fail");
		$finish;
	end

endmodule
